// ===== src/ddeo_pkg.sv =====
// Shared constants, types and tables for the wheel odometry block.
`timescale 1ns / 1ps
package ddeo_pkg;
	localparam int CORDIC_STEPS_DEF = 24;
	localparam int POS_FRAC_DEF = 16;
	localparam logic [31:0] MPC_RESET = 32'd1262723;
	localparam logic [31:0] HPC_RESET = 32'd1860812;
	localparam logic [33:0] GAIN_Q30 = 34'd652032874;
	localparam logic [0:0] REG_MPC = 1'b0;
	localparam logic [0:0] REG_HPC = 1'b1;

	typedef struct packed {
		logic start;
	} ctl_t;

	function automatic logic [31:0] atan_entry(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0: r = 32'd536870912;
			5'd1: r = 32'd316933406;
			5'd2: r = 32'd167458907;
			5'd3: r = 32'd85004756;
			5'd4: r = 32'd42667331;
			5'd5: r = 32'd21354465;
			5'd6: r = 32'd10679838;
			5'd7: r = 32'd5340245;
			5'd8: r = 32'd2670163;
			5'd9: r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			5'd24: r = 32'd41;
			5'd25: r = 32'd20;
			5'd26: r = 32'd10;
			5'd27: r = 32'd5;
			5'd28: r = 32'd3;
			5'd29: r = 32'd1;
			5'd30: r = 32'd1;
			default: r = 32'd0;
		endcase
		return r;
	endfunction
endpackage

// ===== src/ddeo_cordic.sv =====
// Iterative rotation-mode CORDIC giving cosine and sine of a binary angle.
`timescale 1ns / 1ps
module ddeo_cordic #(
	parameter int CORDIC_STEPS = ddeo_pkg::CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ddeo_pkg::ctl_t     ctl,
	input  logic [31:0]        angle,
	output logic               done,
	output logic signed [33:0] cos_v,
	output logic signed [33:0] sin_v
);
	localparam int IW = $clog2(CORDIC_STEPS + 1);
	logic signed [33:0] x_q, y_q;
	logic signed [32:0] z_q;
	logic [IW-1:0] i_q;
	logic run_q, flip_q;
	logic [31:0] rot;
	logic signed [33:0] xs, ys;
	logic [31:0] at;

	assign rot = angle + 32'h4000_0000;
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = ddeo_pkg::atan_entry(5'(i_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done <= 1'b0;
			i_q <= '0;
		end else begin
			done <= 1'b0;
			if (ctl.start) begin
				run_q <= 1'b1;
				i_q <= '0;
				flip_q <= rot[31];
				x_q <= ddeo_pkg::GAIN_Q30;
				y_q <= '0;
				z_q <= rot[31] ? 33'(signed'(angle + 32'h8000_0000))
					: 33'(signed'(angle));
			end else if (run_q) begin
				if (i_q == IW'(CORDIC_STEPS)) begin
					run_q <= 1'b0;
					done <= 1'b1;
					if (flip_q) begin
						x_q <= -x_q;
						y_q <= -y_q;
					end
				end else begin
					if (!z_q[32]) begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - 33'(at);
					end else begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + 33'(at);
					end
					i_q <= i_q + 1'b1;
				end
			end
		end
	end
	assign cos_v = x_q;
	assign sin_v = y_q;
endmodule

// ===== src/ddeo_serial_mult.sv =====
// Shift-add multiplier taking one multiplier bit per cycle.
`timescale 1ns / 1ps
module ddeo_serial_mult (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [33:0] a,
	input  logic [33:0] b,
	output logic        done,
	output logic [67:0] prod
);
	logic [33:0] b_q;
	logic [67:0] a_q;
	logic [5:0] n_q;
	logic run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done <= 1'b0;
			n_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				n_q <= '0;
				a_q <= {34'd0, a};
				b_q <= b;
				prod <= '0;
			end else if (run_q) begin
				if (b_q[0]) prod <= prod + a_q;
				a_q <= a_q << 1;
				b_q <= b_q >> 1;
				n_q <= n_q + 1'b1;
				if (n_q == 6'd33) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
endmodule

// ===== src/diff_drive_encoder_odometry_unit.sv =====
// Top level of the differential-drive wheel odometry block.
//   channel | dir | handshake          | payload
//   s_axis  | in  | s_axis_tvalid/ready | left_count, right_count
//   m_axis  | out | m_axis_tvalid/ready | pose and steps, 192 bits
//   cfg     | in  | cfg_valid/ready     | cfg_index, cfg_data
// The four products share one bit-serial multiplier. Each product has a start
// state, shift-add steps over the 34 multiplier bits and a wait state that
// collects the result.
// Reset clears the pose, previous counts and registers to their defaults.
// A finished result waits in the output register; the next beat is accepted
// only after the output register has been taken.
`timescale 1ns / 1ps
module diff_drive_encoder_odometry_unit #(
	parameter int CORDIC_STEPS = ddeo_pkg::CORDIC_STEPS_DEF,
	parameter int POSITION_FRAC_BITS = ddeo_pkg::POS_FRAC_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,  // left_count, right_count
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [191:0] m_axis_tdata,  // x_out, y_out, heading_out, step_x, step_y, step_heading
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [0:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	localparam int SH = 33 - POSITION_FRAC_BITS;
	localparam logic [3:0] ST_IDLE = 4'd0, ST_TRAV = 4'd1, ST_HEAD = 4'd2,
		ST_CORD = 4'd3, ST_SX = 4'd4, ST_SY = 4'd5, ST_OUT = 4'd6,
		ST_WTR = 4'd7, ST_WTH = 4'd8, ST_WSX = 4'd9, ST_WSY = 4'd10,
		ST_CST = 4'd11;

	logic [3:0] st_q;
	logic [31:0] mpc_q, hpc_q, pl_q, pr_q, px_q, py_q, ph_q;
	logic [31:0] l_q, r_q, dh_q, sx_q, sy_q;
	logic signed [32:0] sum_q;
	logic signed [33:0] travel_q, cos_q, sin_q;
	logic [33:0] ma, mb;
	logic m_start, m_done, c_done;
	logic [67:0] prod;
	logic signed [33:0] cv, sv;
	ddeo_pkg::ctl_t cctl;
	logic signed [31:0] dl, dr;
	logic signed [32:0] sum_w;
	logic [32:0] mag;
	logic [67:0] tm;
	logic [33:0] tm_sat;
	logic neg_s;
	logic [33:0] fa;
	logic [67:0] sp;
	logic signed [67:0] sr;
	logic signed [31:0] sat;

	assign cfg_ready = 1'b1;
	assign s_axis_tready = (st_q == ST_IDLE) && !m_axis_tvalid;
	assign dl = signed'(s_axis_tdata[31:0] - pl_q);
	assign dr = signed'(s_axis_tdata[63:32] - pr_q);
	assign sum_w = 33'(dl) + 33'(dr);
	assign mag = sum_q[32] ? 33'(-sum_q) : 33'(sum_q);
	assign tm = (prod >> SH) + 68'(prod[SH-1]);
	assign tm_sat = (tm > 68'h7FFF_FFFF) ? 34'h7FFF_FFFF : 34'(tm);

	// Step products use magnitudes; sign is restored before rounding.
	assign fa = (st_q == ST_SX || st_q == ST_WSX)
		? (cos_q[33] ? 34'(-cos_q) : 34'(cos_q))
		: (sin_q[33] ? 34'(-sin_q) : 34'(sin_q));
	assign neg_s = travel_q[33] ^ ((st_q == ST_WSX) ? cos_q[33] : sin_q[33]);
	assign sp = neg_s ? -prod : prod;
	assign sr = (signed'(sp) + 68'sd536870912) >>> 30;
	assign sat = (sr > 68'sd2147483647) ? 32'h7FFF_FFFF
		: (sr < -68'sd2147483648) ? 32'h8000_0000 : 32'(sr);

	always_comb begin
		ma = '0;
		mb = '0;
		m_start = 1'b0;
		unique case (st_q)
			ST_TRAV: begin
				ma = 34'(mag); mb = 34'(mpc_q); m_start = 1'b1;
			end
			ST_HEAD: begin
				ma = {2'b00, dh_q}; mb = 34'(hpc_q);
				m_start = 1'b1;
			end
			ST_SX, ST_SY: begin
				ma = travel_q[33] ? 34'(-travel_q) : 34'(travel_q); mb = fa;
				m_start = 1'b1;
			end
			default: ;
		endcase
	end

	// The CORDIC is started by a single cycle in its own state.
	assign cctl.start = (st_q == ST_CST);

	ddeo_serial_mult u_mult (
		.clk(clk), .arst_n(arst_n), .start(m_start), .a(ma), .b(mb),
		.done(m_done), .prod(prod)
	);
	ddeo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .ctl(cctl), .angle(ph_q),
		.done(c_done), .cos_v(cv), .sin_v(sv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			mpc_q <= ddeo_pkg::MPC_RESET;
			hpc_q <= ddeo_pkg::HPC_RESET;
			pl_q <= '0; pr_q <= '0; px_q <= '0; py_q <= '0; ph_q <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == ddeo_pkg::REG_MPC) mpc_q <= cfg_data;
				else mpc_q <= mpc_q;
				if (cfg_index == ddeo_pkg::REG_HPC) hpc_q <= cfg_data;
			end
			if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					l_q <= s_axis_tdata[31:0];
					r_q <= s_axis_tdata[63:32];
					sum_q <= sum_w;
					dh_q <= 32'(dr - dl);
					st_q <= ST_TRAV;
				end
				ST_TRAV: st_q <= ST_WTR;
				ST_WTR: if (m_done) begin
					travel_q <= sum_q[32] ? -tm_sat : tm_sat;
					st_q <= ST_HEAD;
				end
				ST_HEAD: st_q <= ST_WTH;
				ST_WTH: if (m_done) begin
					dh_q <= prod[31:0];
					st_q <= ST_CST;
				end
				ST_CST: st_q <= ST_CORD;
				ST_CORD: if (c_done) begin
					cos_q <= cv;
					sin_q <= sv;
					st_q <= ST_SX;
				end
				ST_SX: st_q <= ST_WSX;
				ST_WSX: if (m_done) begin
					sx_q <= sat;
					st_q <= ST_SY;
				end
				ST_SY: st_q <= ST_WSY;
				ST_WSY: if (m_done) begin
					sy_q <= sat;
					st_q <= ST_OUT;
				end
				ST_OUT: begin
					px_q <= px_q + sx_q;
					py_q <= py_q + sy_q;
					ph_q <= ph_q + dh_q;
					pl_q <= l_q;
					pr_q <= r_q;
					m_axis_tdata <= {dh_q, sy_q, sx_q, ph_q + dh_q,
						py_q + sy_q, px_q + sx_q};
					m_axis_tvalid <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result lost");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> !s_axis_tready) else $error("accept while busy");
	a_out_after: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_OUT) |=> m_axis_tvalid) else $error("no result");
`endif
endmodule

// ===== tb/tb_top.sv =====
// Testbench for the wheel odometry block: table-driven and random beats checked against a pose predictor.
`timescale 1ns / 1ps
module tb_top;
	typedef struct packed {
		logic [31:0] x_out;
		logic [31:0] y_out;
		logic [31:0] heading_out;
		logic [31:0] step_x;
		logic [31:0] step_y;
		logic [31:0] step_heading;
	} pose_t;

	typedef struct {
		logic [31:0] left_count;
		logic [31:0] right_count;
		bit          typed;
		pose_t       pose;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [191:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [0:0] cfg_index = ddeo_pkg::REG_MPC;
	logic [31:0] cfg_data = '0;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned fail_count = 0;
	pose_t pose_queue[$];

	// Predictor state.
	logic [31:0] mpc_reg = ddeo_pkg::MPC_RESET;
	logic [31:0] hpc_reg = ddeo_pkg::HPC_RESET;
	logic [31:0] last_left = '0;
	logic [31:0] last_right = '0;
	logic [31:0] acc_x = '0;
	logic [31:0] acc_y = '0;
	logic [31:0] acc_heading = '0;

	localparam logic [31:0] ARCTAN_Q32 [32] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
	};

	diff_drive_encoder_odometry_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic longint scale_rounded(longint travel, longint factor);
		longint r;
		r = (travel * factor + 64'sd536870912) >>> 30;
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		if (r < -64'sd2147483648) r = -64'sd2147483648;
		return r;
	endfunction

	function automatic pose_t advance_pose(logic [31:0] l, logic [31:0] r);
		pose_t p;
		longint dl, dr, sum, travel, cx, sy, z, nx, sx_s, sy_s;
		logic [63:0] mag, prod, tm;
		logic [31:0] ang, dh, t;
		bit flip;
		dl = longint'($signed(l - last_left));
		dr = longint'($signed(r - last_right));
		sum = dl + dr;
		mag = (sum < 0) ? -sum : sum;
		prod = mag * {32'd0, mpc_reg};
		tm = (prod >> (33 - ddeo_pkg::POS_FRAC_DEF))
			+ ((prod >> (32 - ddeo_pkg::POS_FRAC_DEF)) & 64'd1);
		if (tm > 64'h7FFF_FFFF) tm = 64'h7FFF_FFFF;
		travel = (sum < 0) ? -longint'(tm) : longint'(tm);
		dh = 32'(dr - dl) * hpc_reg;
		// Rotation-mode CORDIC on the old heading; the back half-turn is folded by pi.
		ang = acc_heading;
		t = ang + 32'h4000_0000;
		flip = t[31];
		if (flip) ang = ang + 32'h8000_0000;
		z = longint'($signed(ang));
		cx = longint'(ddeo_pkg::GAIN_Q30);
		sy = 0;
		for (int i = 0; i < ddeo_pkg::CORDIC_STEPS_DEF && i < 32; i++) begin
			if (z >= 0) begin
				nx = cx - (sy >>> i);
				sy = sy + (cx >>> i);
				z = z - longint'(ARCTAN_Q32[i]);
			end else begin
				nx = cx + (sy >>> i);
				sy = sy - (cx >>> i);
				z = z + longint'(ARCTAN_Q32[i]);
			end
			cx = nx;
		end
		if (flip) begin
			cx = -cx;
			sy = -sy;
		end
		sx_s = scale_rounded(travel, cx);
		sy_s = scale_rounded(travel, sy);
		acc_x = acc_x + 32'(sx_s);
		acc_y = acc_y + 32'(sy_s);
		acc_heading = acc_heading + dh;
		last_left = l;
		last_right = r;
		p.x_out = acc_x;
		p.y_out = acc_y;
		p.heading_out = acc_heading;
		p.step_x = 32'(sx_s);
		p.step_y = 32'(sy_s);
		p.step_heading = dh;
		return p;
	endfunction

	// Output side: random stalls, and every taken beat is checked against the oldest pose.
	always @(posedge clk) begin
		pose_t want, got;
		if (m_axis_tvalid && m_axis_tready) begin
			got.x_out = m_axis_tdata[31:0];
			got.y_out = m_axis_tdata[63:32];
			got.heading_out = m_axis_tdata[95:64];
			got.step_x = m_axis_tdata[127:96];
			got.step_y = m_axis_tdata[159:128];
			got.step_heading = m_axis_tdata[191:160];
			if (pose_queue.size() == 0) begin
				$error("result beat with no pose waiting");
				fail_count++;
			end else begin
				want = pose_queue.pop_front();
				if (got.x_out !== want.x_out) begin
					$error("x_out expected %h actual %h", want.x_out, got.x_out);
					fail_count++;
				end
				if (got.y_out !== want.y_out) begin
					$error("y_out expected %h actual %h", want.y_out, got.y_out);
					fail_count++;
				end
				if (got.heading_out !== want.heading_out) begin
					$error("heading_out expected %h actual %h", want.heading_out,
						got.heading_out);
					fail_count++;
				end
				if (got.step_x !== want.step_x) begin
					$error("step_x expected %h actual %h", want.step_x, got.step_x);
					fail_count++;
				end
				if (got.step_y !== want.step_y) begin
					$error("step_y expected %h actual %h", want.step_y, got.step_y);
					fail_count++;
				end
				if (got.step_heading !== want.step_heading) begin
					$error("step_heading expected %h actual %h", want.step_heading,
						got.step_heading);
					fail_count++;
				end
			end
		end
		m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Valid stays high between back-to-back beats; this task lowers it only when a gap is taken.
	task automatic send_counts(logic [31:0] l, logic [31:0] r, bit typed, pose_t typed_pose);
		pose_t p;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {r, l};
		do @(posedge clk); while (!s_axis_tready);
		p = advance_pose(l, r);
		pose_queue.push_back(typed ? typed_pose : p);
	endtask

	// Valid drops after each write so that writes never overlap.
	task automatic write_reg(logic [0:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == ddeo_pkg::REG_MPC) mpc_reg = val;
		else hpc_reg = val;
		@(posedge clk);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pose_queue.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic random_counts(int n);
		logic [31:0] l, r;
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(0, 9))
				0: begin
					l = $urandom();
					r = $urandom();
				end
				1: begin
					l = last_left + $urandom_range(0, 2000000) - 1000000;
					r = last_right + $urandom_range(0, 2000000) - 1000000;
				end
				default: begin
					// Ordinary driving: small forward, backward and turning moves.
					l = last_left + $urandom_range(0, 400) - 200;
					r = last_right + $urandom_range(0, 400) - 200;
				end
			endcase
			send_counts(l, r, 1'b0, '0);
		end
	endtask

	stim_row_t directed_rows [] = '{
		'{32'd0, 32'd0, 1'b1, '0},
		'{32'd1, 32'd1, 1'b0, '0},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
		'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0},
		'{32'h8000_0000, 32'h8000_0000, 1'b0, '0},
		'{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0},
		'{32'd0, 32'd0, 1'b0, '0},
		'{32'd0, 32'd0, 1'b0, '0},
		'{32'd5, 32'hFFFF_FFFB, 1'b0, '0},
		'{32'hFFFF_FFF0, 32'd16, 1'b0, '0},
		'{32'd100000, 32'd100000, 1'b0, '0},
		'{32'd90000, 32'd110000, 1'b0, '0},
		'{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
		'{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
		'{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0}
	};

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_counts(directed_rows[i].left_count, directed_rows[i].right_count,
				directed_rows[i].typed, directed_rows[i].pose);
		random_counts(110);
		drain_results();

		write_reg(ddeo_pkg::REG_MPC, 32'hFFFF_FFFF);
		write_reg(ddeo_pkg::REG_HPC, 32'hFFFF_FFFF);
		send_idle_pct = 72;
		random_counts(125);
		drain_results();

		write_reg(ddeo_pkg::REG_MPC, 32'd1);
		write_reg(ddeo_pkg::REG_HPC, 32'd1);
		send_idle_pct = 0;
		recv_stall_pct = 72;
		random_counts(125);
		drain_results();

		// A zero travel register leaves only turning.
		write_reg(ddeo_pkg::REG_MPC, 32'd0);
		write_reg(ddeo_pkg::REG_HPC, 32'h0400_0000);
		send_idle_pct = 38;
		recv_stall_pct = 38;
		random_counts(125);
		drain_results();

		write_reg(ddeo_pkg::REG_MPC, $urandom());
		write_reg(ddeo_pkg::REG_HPC, 32'd0);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_counts(125);
		drain_results();

		write_reg(ddeo_pkg::REG_MPC, $urandom_range(1000000, 50000000));
		write_reg(ddeo_pkg::REG_HPC, $urandom_range(100000, 40000000));
		send_idle_pct = 38;
		recv_stall_pct = 38;
		random_counts(125);
		drain_results();

		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
